// File: design/rs1613_pkg.sv
// Package for the RS(16,13) parity encoder: GF(256) constants, the
// constant-multiply function and the types shared by the modules.
// No dependencies.
`default_nettype none
package rs1613_pkg;

  localparam int unsigned NUM_PAR = 3;

  // low byte of the field polynomial x^8+x^4+x^3+x^2+1
  localparam logic [7:0] GF_POLY_LOW = 8'h1D;

  // generator g(x) = x^3 + 0x0e x^2 + 0x38 x + 0x40
  localparam logic [7:0] GEN_C0 = 8'h0E;
  localparam logic [7:0] GEN_C1 = 8'h38;
  localparam logic [7:0] GEN_C2 = 8'h40;

  typedef logic [NUM_PAR-1:0][7:0] par_t;

  typedef struct packed {
    logic step;   // data item accepted this cycle
    logic last;   // it is the final data byte of the block
  } lfsr_ctrl_t;

  // GF(256) product; with one operand constant this folds to an XOR tree
  function automatic logic [7:0] gf_mul(input logic [7:0] x, input logic [7:0] y);
    logic [7:0] acc;
    logic [7:0] a;
    acc = 8'h00;
    a   = x;
    for (int k = 0; k < 8; k++) begin
      if (y[k]) begin
        acc = acc ^ a;
      end
      a = a[7] ? ({a[6:0], 1'b0} ^ GF_POLY_LOW) : {a[6:0], 1'b0};
    end
    return acc;
  endfunction

endpackage
`default_nettype wire

// File: design/rs_16_13_parity_encoder.sv
// Top level of the RS(16,13) systematic parity encoder over GF(256).
// Depends on rs1613_pkg and rs1613_lfsr.
//
// Each data byte on the slave stream is registered and passed to the master
// stream in the next cycle, one byte per cycle while the master side accepts
// and no parity is pending. After the DATA_BYTES-th byte of a block the
// three parity bytes p0, p1, p2 follow, tlast set on p2: s_tready is held low
// while the parity buffer drains through the output register. A full output
// register that is taken in the same cycle does not stall the input.
`default_nettype none
module rs_16_13_parity_encoder #(
  parameter int unsigned DATA_BYTES = 13
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] data_byte
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,   // [7:0] out_byte
  output logic            m_tlast    // block_end
);
  import rs1613_pkg::*;

  localparam int unsigned CW = $clog2(DATA_BYTES + 1);
  localparam logic [CW-1:0] LAST_IDX = CW'(DATA_BYTES - 1);

  logic [CW-1:0] count;
  par_t          par_buf;
  logic [1:0]    par_left;
  par_t          par_next;
  lfsr_ctrl_t    ctrl;
  logic          out_free;
  logic          in_fire;
  logic          is_last;

  assign out_free  = !m_tvalid || m_tready;
  assign s_tready  = out_free && (par_left == 2'd0);
  assign in_fire   = s_tvalid && s_tready;
  assign is_last   = (count == LAST_IDX);
  assign ctrl.step = in_fire;
  assign ctrl.last = is_last;

  rs1613_lfsr u_lfsr (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .data     (s_tdata),
    .par_next (par_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      par_left <= 2'd0;
      m_tvalid <= 1'b0;
    end else if (in_fire) begin
      count    <= is_last ? '0 : count + CW'(1);
      par_left <= is_last ? 2'(NUM_PAR) : 2'd0;
      m_tvalid <= 1'b1;
    end else if (out_free) begin
      m_tvalid <= (par_left != 2'd0);
      if (par_left != 2'd0) begin
        par_left <= par_left - 2'd1;
      end
    end
  end

  // payload: output register and the parity shift buffer
  always_ff @(posedge clk) begin
    if (in_fire) begin
      m_tdata <= s_tdata;
      m_tlast <= 1'b0;
      if (is_last) begin
        par_buf <= par_next;
      end
    end else if (out_free && par_left != 2'd0) begin
      m_tdata <= par_buf[0];
      m_tlast <= (par_left == 2'd1);
      par_buf <= {8'h00, par_buf[NUM_PAR-1:1]};
    end
  end

  a_par_load: assert property (@(posedge clk) disable iff (rst)
    in_fire && is_last |=> par_left == 2'(NUM_PAR))
    else $error("parity buffer not loaded after final data byte");

  a_last_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> par_left == 2'd0)
    else $error("tlast shown with parity still pending");

  a_stall: assert property (@(posedge clk) disable iff (rst)
    par_left != 2'd0 |-> !s_tready)
    else $error("input taken while parity pending");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= LAST_IDX)
    else $error("byte count past block length");

endmodule
`default_nettype wire

// File: design/rs1613_lfsr.sv
// Three-byte parity LFSR dividing by the RS generator polynomial.
// Depends on rs1613_pkg.
`default_nettype none
module rs1613_lfsr (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire rs1613_pkg::lfsr_ctrl_t ctrl,
  input  wire logic [7:0]            data,
  output rs1613_pkg::par_t           par_next
);
  import rs1613_pkg::*;

  par_t       par;
  logic [7:0] fb;

  always_comb begin
    fb          = data ^ par[0];
    par_next[0] = par[1] ^ gf_mul(GEN_C0, fb);
    par_next[1] = par[2] ^ gf_mul(GEN_C1, fb);
    par_next[2] = gf_mul(GEN_C2, fb);
  end

  // cleared after the final byte; the finished parity is taken from par_next
  always_ff @(posedge clk) begin
    if (rst) begin
      par <= '0;
    end else if (ctrl.step) begin
      par <= ctrl.last ? par_t'(0) : par_next;
    end
  end

endmodule
`default_nettype wire
